>>> sv/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same, on the block's own clock and reset.
`define ASSERT_ALWAYS(lbl, prop) \
    `ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

>>> sv/sct_pkg.sv
// Types and constants shared by the tokenizer modules.
`default_nettype none
package sct_pkg;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned SLOT_W      = 3;

    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;
    localparam logic [1:0] KIND_RSVD      = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    // All results caused by one input item.
    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] items;
        logic [SLOT_W-1:0]           count;
    } t_bundle;

endpackage
`default_nettype wire

>>> sv/sct_queue.sv
// Two-entry queue of result bundles between the front and back ends.
`default_nettype none
module sct_queue
    import sct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire t_bundle i_wr_data,
    output logic         o_full,
    input  wire logic    i_rd,
    output t_bundle      o_rd_data,
    output logic         o_valid
);

    t_bundle    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ok;
    logic       n_rd_ok;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign n_wr_ok   = i_wr && !o_full;
    assign n_rd_ok   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (n_wr_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_rd_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({n_wr_ok, n_rd_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/sct_front.sv
// Front end: classifies each byte, keeps lexer state, builds the result bundle.
`default_nettype none
module sct_front
    import sct_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_wr,
    output t_bundle       o_bundle
);

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_AND  = 2'd1;
    localparam logic [1:0] PEND_OR   = 2'd2;
    localparam logic [1:0] PEND_GT   = 2'd3;

    logic       r_quoting, n_quoting;
    logic       r_escaping, n_escaping;
    logic       r_in_comment, n_in_comment;
    logic       r_token_open, n_token_open;
    logic [1:0] r_pending, n_pending;
    t_bundle    n_bundle;

    function automatic logic [7:0] f_pend_char(input logic [1:0] code);
        case (code)
            PEND_AND: return 8'h26;
            PEND_OR:  return 8'h7C;
            default:  return 8'h3E;
        endcase
    endfunction

    // Results past the fifth are dropped.
    function automatic t_bundle f_add(input t_bundle b, input logic [1:0] kind,
                                      input logic [7:0] ch);
        t_bundle r;
        r = b;
        if (b.count < SLOT_W'(MAX_RESULTS)) begin
            r.items[b.count].kind     = kind;
            r.items[b.count].out_char = ch;
            r.items[b.count].run_last = 1'b0;
            r.count                   = b.count + SLOT_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] p;
        logic       done;
        c            = i_item.in_char;
        p            = f_pend_char(r_pending);
        done         = 1'b0;
        n_quoting    = r_quoting;
        n_escaping   = r_escaping;
        n_in_comment = r_in_comment;
        n_token_open = r_token_open;
        n_pending    = r_pending;
        n_bundle     = '0;

        if (c != 8'h00) begin
            if (r_pending != PEND_NONE) begin
                n_pending = PEND_NONE;
                n_bundle  = f_add(n_bundle, KIND_BYTE, p);
                if (c == p) begin
                    n_bundle = f_add(n_bundle, KIND_BYTE, c);
                    done     = 1'b1;
                end
                n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
            end
            if (!done && !r_in_comment) begin
                if (r_escaping) begin
                    n_bundle     = f_add(n_bundle, KIND_BYTE, c);
                    n_token_open = 1'b1;
                    n_escaping   = 1'b0;
                end else if (c == 8'h5C) begin
                    n_escaping = 1'b1;
                end else if (c == 8'h22) begin
                    n_quoting    = ~r_quoting;
                    n_bundle     = f_add(n_bundle, KIND_BYTE, c);
                    n_token_open = 1'b1;
                end else if (!r_quoting && c == 8'h23) begin
                    n_in_comment = 1'b1;
                end else if (!r_quoting &&
                             (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D})) begin
                    if (r_token_open) begin
                        n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
                    end
                    n_token_open = 1'b0;
                end else if (!r_quoting &&
                             (c inside {8'h7C, 8'h26, 8'h3B, 8'h3E, 8'h3C, 8'h28, 8'h29})) begin
                    if (r_token_open) begin
                        n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
                    end
                    n_token_open = 1'b0;
                    case (c)
                        8'h26: n_pending = PEND_AND;
                        8'h7C: n_pending = PEND_OR;
                        8'h3E: n_pending = PEND_GT;
                        default: begin
                            n_bundle = f_add(n_bundle, KIND_BYTE, c);
                            n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
                        end
                    endcase
                end else begin
                    n_bundle     = f_add(n_bundle, KIND_BYTE, c);
                    n_token_open = 1'b1;
                end
            end
        end

        if (i_item.line_end) begin
            if (n_pending != PEND_NONE) begin
                n_bundle = f_add(n_bundle, KIND_BYTE, f_pend_char(n_pending));
                n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
            end
            if (n_token_open) begin
                n_bundle = f_add(n_bundle, KIND_TOKEN_END, 8'h00);
            end
            n_bundle     = f_add(n_bundle, KIND_LINE_END, 8'h00);
            n_quoting    = 1'b0;
            n_escaping   = 1'b0;
            n_in_comment = 1'b0;
            n_token_open = 1'b0;
            n_pending    = PEND_NONE;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_bundle.items[i].run_last = (n_bundle.count == SLOT_W'(i + 1));
        end
    end

    assign o_bundle = n_bundle;
    assign o_wr     = i_accept && (n_bundle.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoting    <= 1'b0;
            r_escaping   <= 1'b0;
            r_in_comment <= 1'b0;
            r_token_open <= 1'b0;
            r_pending    <= PEND_NONE;
        end else if (i_accept) begin
            r_quoting    <= n_quoting;
            r_escaping   <= n_escaping;
            r_in_comment <= n_in_comment;
            r_token_open <= n_token_open;
            r_pending    <= n_pending;
        end
    end

endmodule
`default_nettype wire

>>> sv/sct_back.sv
// Back end: walks the head bundle into the output register, one result per cycle while results are popped.
`default_nettype none
module sct_back
    import sct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_bundle i_q_data,
    output logic         o_q_rd,
    input  wire logic    i_pop,
    output logic         o_empty,
    output t_out_item    o_result
);

    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              n_load;
    logic              n_last;

    assign n_load   = i_q_valid && (!r_out_valid || i_pop);
    assign n_last   = (r_slot == i_q_data.count - SLOT_W'(1));
    assign o_q_rd   = n_load && n_last;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= i_q_data.items[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
                r_slot      <= n_last ? '0 : r_slot + SLOT_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/shell_command_tokenizer_top.sv
// Shell command tokenizer: byte stream in, token bytes and marks out.
//
// Input queue port: one command-line byte per transaction (in_char, line_end),
// taken when i_push is high and o_full is low. in_char zero carries no byte.
// Result queue port: each result (kind, out_char, run_last) is shown while
// o_empty is low and is taken when i_pop is high. run_last flags the final
// result caused by one input byte; one byte causes zero to five results.
// A result passes through the bundle queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver pops every result; the single output register drains
// a byte's results one per cycle while popped, holding the back end. A
// two-entry bundle queue lets the front keep taking bytes meanwhile until it fills.
// When the receiver stalls, the output holds and o_full rises once the queue
// is full. Synchronous reset clears lexer state, queue and output register;
// the block is ready as soon as reset is released.
`default_nettype none
module shell_command_tokenizer_top
    import sct_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_in_item,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_out_item     o_out_item
);

    logic    accept;
    logic    q_wr;
    logic    q_rd;
    logic    q_valid;
    t_bundle q_wr_data;
    t_bundle q_rd_data;

    assign accept = i_push && !o_full;

    sct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_wr     (q_wr),
        .o_bundle (q_wr_data)
    );

    sct_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (o_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_valid   (q_valid)
    );

    sct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rd_data),
        .o_q_rd    (q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (o_out_item)
    );

endmodule
`default_nettype wire

>>> sv/sct_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sct_checker
    import sct_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_full,
    input wire logic      i_pop,
    input wire logic      o_empty,
    input wire t_out_item o_out_item
);

    logic w_mark;
    logic w_line;
    logic w_hold;

    assign w_mark = !o_empty && (o_out_item.kind != KIND_BYTE);
    assign w_line = !o_empty && (o_out_item.kind == KIND_LINE_END);
    assign w_hold = !o_empty && !i_pop;

    `ASSERT_ALWAYS(kind_legal, !o_empty |-> o_out_item.kind != KIND_RSVD)

    `ASSERT_ALWAYS(mark_has_no_char, w_mark |-> o_out_item.out_char == 8'h00)

    `ASSERT_ALWAYS(line_end_is_last, w_line |-> o_out_item.run_last)

    `ASSERT_ALWAYS(stalled_result_holds, w_hold |=> (!o_empty && $stable(o_out_item)))

    `ASSERT_ALWAYS(empty_after_reset, $rose(i_rst_n) |-> o_empty && !o_full)

endmodule

bind shell_command_tokenizer_top sct_checker u_sct_checker (.*);
`default_nettype wire

>>> tb/tb_shell_command_tokenizer_top.sv
// Self-checking testbench for the shell command tokenizer, with a built-in lexer predictor.
module tb_shell_command_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef enum logic [1:0] {PEND_NONE, PEND_AMP, PEND_BAR, PEND_GT} t_pend;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    t_in_item  i_in_item;
    logic      i_pop;
    logic      o_empty;
    t_out_item o_out_item;

    shell_command_tokenizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in_item  (i_in_item),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out_item (o_out_item)
    );

    // predictor state
    bit    lx_quoting    = 1'b0;
    bit    lx_escaping   = 1'b0;
    bit    lx_comment    = 1'b0;
    bit    lx_token_open = 1'b0;
    t_pend lx_pending    = PEND_NONE;

    t_out_item step_results[$];
    t_out_item expected_tokens[$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int lines_seen      = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_cycles     = 0;
    int cycle_count     = 0;
    logic [7:0] prev_byte = CH_NUL;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n   = 1'b0;
        i_push    = 1'b0;
        i_pop     = 1'b0;
        i_in_item = '0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_tokens.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic logic [7:0] pend_byte(t_pend p);
        case (p)
            PEND_AMP: return CH_AMP;
            PEND_BAR: return CH_BAR;
            default:  return CH_GT;
        endcase
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_operator(logic [7:0] c);
        case (c)
            CH_BAR, CH_AMP, CH_SEMI, CH_GT, CH_LT, CH_LPAREN, CH_RPAREN: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void add_result(logic [1:0] k, logic [7:0] ch);
        t_out_item r;
        if (step_results.size() < MAX_RESULTS) begin
            r.kind     = k;
            r.out_char = ch;
            r.run_last = 1'b0;
            step_results.push_back(r);
        end
    endfunction

    function automatic void close_token();
        if (lx_token_open) begin
            add_result(KIND_TOKEN_END, CH_NUL);
            lx_token_open = 1'b0;
        end
    endfunction

    function automatic void add_token_byte(logic [7:0] c);
        add_result(KIND_BYTE, c);
        lx_token_open = 1'b1;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [7:0] p;
        if (lx_pending != PEND_NONE) begin
            p = pend_byte(lx_pending);
            lx_pending = PEND_NONE;
            add_result(KIND_BYTE, p);
            if (c == p) begin
                // doubled operator: && || >>
                add_result(KIND_BYTE, c);
                add_result(KIND_TOKEN_END, CH_NUL);
                return;
            end
            add_result(KIND_TOKEN_END, CH_NUL);
        end
        if (lx_comment)
            return;
        if (lx_escaping) begin
            add_token_byte(c);
            lx_escaping = 1'b0;
        end else if (c == CH_BSLASH) begin
            lx_escaping = 1'b1;
        end else if (c == CH_QUOTE) begin
            lx_quoting = ~lx_quoting;
            add_token_byte(c);
        end else if (!lx_quoting && c == CH_HASH) begin
            lx_comment = 1'b1;
        end else if (!lx_quoting && is_blank(c)) begin
            close_token();
        end else if (!lx_quoting && is_operator(c)) begin
            close_token();
            case (c)
                CH_AMP: lx_pending = PEND_AMP;
                CH_BAR: lx_pending = PEND_BAR;
                CH_GT:  lx_pending = PEND_GT;
                default: begin
                    add_result(KIND_BYTE, c);
                    add_result(KIND_TOKEN_END, CH_NUL);
                end
            endcase
        end else begin
            add_token_byte(c);
        end
    endfunction

    function automatic void predict_tokens(t_in_item it);
        t_out_item r;
        step_results.delete();
        if (it.in_char != CH_NUL)
            lex_byte(it.in_char);
        if (it.line_end) begin
            if (lx_pending != PEND_NONE) begin
                add_result(KIND_BYTE, pend_byte(lx_pending));
                add_result(KIND_TOKEN_END, CH_NUL);
            end
            close_token();
            add_result(KIND_LINE_END, CH_NUL);
            lx_quoting    = 1'b0;
            lx_escaping   = 1'b0;
            lx_comment    = 1'b0;
            lx_token_open = 1'b0;
            lx_pending    = PEND_NONE;
            lines_seen++;
        end
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.run_last = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i])
            expected_tokens.push_back(step_results[i]);
    endfunction

    // ---------------- result side ----------------
    initial begin
        t_out_item got;
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (i_pop && !o_empty) begin
                    got = o_out_item;
                    results_checked++;
                    if (expected_tokens.size() == 0) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("unexpected result: kind=%0d char=%02h last=%0b",
                                     got.kind, got.out_char, got.run_last);
                    end else begin
                        want = expected_tokens.pop_front();
                        if (got.kind !== want.kind || got.out_char !== want.out_char ||
                            got.run_last !== want.run_last) begin
                            error_count++;
                            if (error_count <= MAX_REPORTS)
                                $display({"mismatch #%0d (exp/got): kind %0d/%0d, ",
                                          "char %02h/%02h, last %0b/%0b"},
                                         results_checked, want.kind, got.kind,
                                         want.out_char, got.out_char,
                                         want.run_last, got.run_last);
                        end
                    end
                end
                if (hold_cycles > 0) begin
                    hold_cycles--;
                    i_pop <= 1'b0;
                end else begin
                    i_pop <= ($urandom_range(99) >= recv_idle_pct);
                end
            end
        end
    end

    // ---------------- input side ----------------
    task automatic send_byte(logic [7:0] c, logic le);
        t_in_item it;
        it.in_char  = c;
        it.line_end = le;
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_full);
        predict_tokens(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(9))
            0, 1, 2: return CH_AMP;
            3, 4:    return CH_BAR;
            5, 6:    return CH_GT;
            7:       return CH_SEMI;
            8:       return CH_LT;
            default: return ($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // shell-like byte mix; repeats &, | and > often so that merging is exercised
    function automatic logic [7:0] command_byte();
        int r;
        r = $urandom_range(99);
        if ((prev_byte == CH_AMP || prev_byte == CH_BAR || prev_byte == CH_GT) &&
            $urandom_range(2) == 0)
            return prev_byte;
        if (r < 38) return 8'h61 + 8'($urandom_range(25));
        if (r < 52) return CH_SPACE;
        if (r < 57) return pick_blank();
        if (r < 73) return pick_operator();
        if (r < 79) return CH_QUOTE;
        if (r < 84) return CH_BSLASH;
        if (r < 87) return CH_HASH;
        if (r < 90) return CH_NUL;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_line();
        int len;
        logic [7:0] c;
        len = $urandom_range(16, 1);
        for (int k = 0; k < len; k++) begin
            c = command_byte();
            prev_byte = c;
            send_byte(c, k == len - 1);
        end
    endtask

    task automatic send_noise(int n);
        for (int k = 0; k < n; k++)
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    endtask

    // ---------------- tests ----------------
    task automatic test_lexer_corner_cases();
        // pending operators: mismatch, doubling across an empty byte, flush at line end
        send_byte("x", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BAR, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_BAR, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(CH_NUL, 1'b1);
        // escaped quote, quoted blank and hash, comment with a token open
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_HASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_HASH, 1'b0);
        send_byte("z", 1'b1);
        // blanks with no open token, single-byte operators, trailing backslash
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_LPAREN, 1'b0);
        send_byte(CH_VT, 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_BSLASH, 1'b1);
        // quote still open at line end
        send_byte(CH_QUOTE, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_lines(int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(9) == 0)
                send_noise($urandom_range(12, 1));
            else
                send_random_line();
        end
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_full_stall();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_cycles   = 150;
        test_random_lines(35);
        wait_drained();
        send_idle_pct = saved_idle;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 75;
        test_lexer_corner_cases();
        test_random_lines(50);

        send_idle_pct = 75;
        recv_idle_pct = 20;
        test_random_lines(50);
        test_full_stall();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(45);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_tokens.size() != 0)
            error_count++;

        $display("%0d bytes over %0d lines lexed, %0d results checked, %0d failures",
                 items_sent, lines_seen, results_checked, error_count);
        $display("covered escapes, quoting, comments, operator merging and a full-queue stall");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/sct_pkg.sv
sv/sct_queue.sv
sv/sct_front.sv
sv/sct_back.sv
sv/shell_command_tokenizer_top.sv
sv/sct_checker.sv
tb/tb_shell_command_tokenizer_top.sv
